// File: design/lis_pkg.sv
package lis_pkg;

    localparam int MAX_LEN = 1024;
    localparam int VALUE_W = 32;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic start_item;
        logic search_done;
        logic out_free;
    } t_sts;

endpackage

// File: design/lis_ram.sv
module lis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/lis_datapath.sv
module lis_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lis_pkg::t_cmd                i_cmd,
    output lis_pkg::t_sts                o_sts,
    input  logic [lis_pkg::VALUE_W-1:0]  i_value,
    input  logic                         i_first,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [lis_pkg::LEN_W-1:0]    o_lis_length,
    output logic                         o_overflow
);

    import lis_pkg::*;

    logic [VALUE_W-1:0] r_key;
    logic               r_start;
    logic [LEN_W-1:0]   r_lo, n_lo;
    logic [LEN_W-1:0]   r_hi, n_hi;
    logic [ADDR_W-1:0]  r_mid, n_mid;
    logic [LEN_W-1:0]   r_len;
    logic               r_ovf;
    logic               r_out_valid;

    logic [VALUE_W-1:0] rd_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [LEN_W:0]     sum;
    logic               ge;
    logic               wr_en;
    logic               append;
    logic               full;

    assign ge     = $signed(rd_data) >= $signed(r_key);
    assign append = (r_lo == r_len) && !r_start;
    assign full   = !(r_len < LEN_W'(MAX_LEN));

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.load) begin
            n_lo = '0;
            n_hi = r_len;
        end else if (i_cmd.step) begin
            if (ge) begin
                n_hi = LEN_W'(r_mid);
            end else begin
                n_lo = LEN_W'(r_mid) + 1'b1;
            end
        end
        sum   = {1'b0, n_lo} + {1'b0, n_hi};
        n_mid = ADDR_W'(sum >> 1);
    end

    assign o_sts.start_item  = i_first || (r_len == '0);
    assign o_sts.search_done = !(n_lo < n_hi);
    assign o_sts.out_free    = !r_out_valid || i_ready;

    assign rd_en   = ((i_cmd.load && !o_sts.start_item) || i_cmd.step) && (n_lo < n_hi);
    assign rd_addr = n_mid;
    assign wr_en   = i_cmd.commit && !(append && full);

    lis_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_LEN)
    ) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ADDR_W'(r_lo)),
        .i_wdata (r_key),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_value;
            r_start <= o_sts.start_item;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (r_start) begin
                    r_len <= LEN_W'(1);
                    r_ovf <= 1'b0;
                end else if (append) begin
                    if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_len <= r_len + 1'b1;
                    end
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_lis_length = r_len;
    assign o_overflow   = r_ovf;

endmodule

// File: design/lis_ctrl.sv
module lis_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lis_pkg::t_sts i_sts,
    output lis_pkg::t_cmd o_cmd
);

    import lis_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_WRITE  = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.start_item ? S_WRITE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_sts.search_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/longest_increasing_subsequence_length.sv
// Streams signed values and returns, one beat per input beat, the length of the longest
// strictly increasing subsequence since reset or the last beat with i_first set, plus a sticky
// overflow flag that is set when an append is lost because the tail table is full.
// Each beat is accepted in idle, then a binary search makes one probe per cycle into the
// tail RAM through its registered read port, then a write-back stores the key and waits
// while the previous result is still pending; a beat that starts a new sequence skips the
// search. One beat is worked on at a time. The tail RAM needs no clearing after reset.
module longest_increasing_subsequence_length (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [lis_pkg::VALUE_W-1:0]  i_value,
    input  logic                         i_first,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lis_pkg::LEN_W-1:0]    o_lis_length,
    output logic                         o_overflow
);

    import lis_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lis_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_value      (i_value),
        .i_first      (i_first),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_lis_length (o_lis_length),
        .o_overflow   (o_overflow)
    );

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lis_length != '0) && (o_lis_length <= LEN_W'(MAX_LEN)))
        else $error("result length out of range");

    a_no_commit_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_valid || i_ready))
        else $error("write-back while previous result still pending");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second beat accepted before first finished");

    a_overflow_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_overflow) |-> (o_lis_length == LEN_W'(MAX_LEN)))
        else $error("overflow set while table not full");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef logic signed [lis_pkg::VALUE_W-1:0] t_sample;

    typedef struct {
        logic [lis_pkg::LEN_W-1:0] len;
        logic                      ovf;
    } t_lis_result;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [lis_pkg::VALUE_W-1:0]  i_value;
    logic                         i_first;
    logic                         o_valid;
    logic                         i_ready;
    logic [lis_pkg::LEN_W-1:0]    o_lis_length;
    logic                         o_overflow;

    longest_increasing_subsequence_length i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .i_first      (i_first),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_lis_length (o_lis_length),
        .o_overflow   (o_overflow)
    );

    // smallest tail per subsequence length
    t_sample     tail_min [lis_pkg::MAX_LEN];
    int          run_len = 0;
    logic        run_ovf = 1'b0;
    t_lis_result pending_lengths [$];

    int err_count   = 0;
    int cycle_count = 0;
    int hold_req    = 0;
    bit quiet       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void update_tails(input t_sample v, input logic start);
        int          lo;
        int          hi;
        int          mid;
        t_lis_result r;
        if (start || run_len == 0) begin
            tail_min[0] = v;
            run_len     = 1;
            run_ovf     = 1'b0;
        end else if (v < tail_min[0]) begin
            tail_min[0] = v;
        end else if (v > tail_min[run_len-1]) begin
            if (run_len < lis_pkg::MAX_LEN) begin
                tail_min[run_len] = v;
                run_len++;
            end else begin
                run_ovf = 1'b1;
            end
        end else begin
            lo = 0;
            hi = run_len - 1;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (tail_min[mid] >= v) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            tail_min[lo] = v;
        end
        r.len = run_len[lis_pkg::LEN_W-1:0];
        r.ovf = run_ovf;
        pending_lengths.insert(pending_lengths.size(), r);
    endfunction

    task automatic send_beat(input t_sample v, input logic start);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        i_first <= start;
        do @(negedge i_clk); while (!o_ready);
        update_tails(v, start);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_lengths.size() != 0);
    endtask

    // receiver: random short stalls, or one long hold when asked
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        t_lis_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_lengths.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual len %0d ovf %0b",
                         $time, o_lis_length, o_overflow);
                err_count++;
            end else begin
                want = pending_lengths.pop_front();
                if (o_lis_length !== want.len) begin
                    $display("%0t: lis_length expected %0d actual %0d",
                             $time, want.len, o_lis_length);
                    err_count++;
                end
                if (o_overflow !== want.ovf) begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want.ovf, o_overflow);
                    err_count++;
                end
            end
        end
    end

    // no first flag right after reset still opens a sequence
    task automatic test_no_open_sequence();
        send_beat(32'sd5, 1'b0);
        send_beat(32'sd5, 1'b0);
        send_beat(-32'sd3, 1'b0);
        send_beat(32'sd7, 1'b0);
        send_beat(32'sd6, 1'b0);
        wait_drained();
    endtask

    task automatic test_extremes();
        t_sample vals [18] = '{
            32'sd0, 32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0, -32'sd1,
            32'sh8000_0000, 32'sh7fff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa,
            32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0001,
            32'sh7fff_fffe, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd1
        };
        bit starts [18] = '{
            1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1
        };
        for (int k = 0; k < 18; k++) begin
            send_beat(vals[k], starts[k]);
        end
        wait_drained();
    endtask

    task automatic test_table_full();
        t_sample v;
        for (int k = 0; k < lis_pkg::MAX_LEN; k++) begin
            v = 32'h8000_0000 + (k << 22);
            send_beat(v, k == 0);
        end
        send_beat(32'sh7fff_ffff, 1'b0);
        send_beat(32'sh7fff_ffff, 1'b0);
        send_beat(32'h8000_0000 + (512 << 22), 1'b0);
        send_beat(32'h8000_0000 + (700 << 22) + 1, 1'b0);
        send_beat(32'sh8000_0000, 1'b0);
        send_beat(32'h8000_0000 + (1023 << 22), 1'b0);
        send_beat(32'sd0, 1'b1);
        send_beat(32'sd1, 1'b0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_req = HOLD_CYCLES;
        for (int k = 0; k < 40; k++) begin
            send_beat($urandom_range(0, 40) - 20, k == 0);
        end
        wait_drained();
    endtask

    task automatic test_random_sequences(input int n_items);
        int      sent;
        int      seq_len;
        int      mode;
        t_sample base;
        t_sample v;
        logic    start;
        sent = 0;
        while (sent < n_items) begin
            mode    = $urandom_range(0, 5);
            seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250)
                                                  : $urandom_range(1, 30);
            base    = $urandom;
            for (int k = 0; k < seq_len && sent < n_items; k++) begin
                case (mode)
                    0: v = $urandom;
                    1: v = $urandom_range(0, 16) - 8;
                    2, 5: v = base + k * 37 + $urandom_range(0, 60) - 30;
                    3: begin
                        case ($urandom_range(0, 6))
                            0: v = 32'sh8000_0000;
                            1: v = 32'sh8000_0001;
                            2: v = -32'sd1;
                            3: v = 32'sd0;
                            4: v = 32'sd1;
                            5: v = 32'sh7fff_fffe;
                            default: v = 32'sh7fff_ffff;
                        endcase
                    end
                    default: v = base - k * 1000 + $urandom_range(0, 3000);
                endcase
                start = (k == 0) || ($urandom_range(0, 49) == 0);
                send_beat(v, start);
                sent++;
            end
            if (!quiet && $urandom_range(0, 7) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        i_first <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_no_open_sequence();
        test_extremes();
        test_table_full();
        test_backpressure();
        test_random_sequences(50);
        quiet = 1'b1;
        test_random_sequences(25);
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && pending_lengths.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: longest_increasing_subsequence_length.f
design/lis_pkg.sv
design/lis_ram.sv
design/lis_datapath.sv
design/lis_ctrl.sv
design/longest_increasing_subsequence_length.sv
tb/sv/tb.sv
